### rtl/core/ssmd_pkg.sv
package ssmd_pkg;

    localparam int NumPlaces  = 4;
    localparam int PlaceWidth = $clog2(NumPlaces);
    localparam int BinWidth   = 24;
    localparam int BcdDigits  = 7;
    localparam int BcdWidth   = 4 * BcdDigits;

    localparam logic [1:0] KindTick   = 2'd0;
    localparam logic [1:0] KindText   = 2'd1;
    localparam logic [1:0] KindNumber = 2'd2;

    localparam logic [31:0] SatLimit   = 32'd10000000;
    localparam logic [7:0]  PointBit   = 8'h80;
    localparam logic [7:0]  BlankGlyph = 8'h00;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] number;
        logic [7:0]  char_first;
        logic [7:0]  char_second;
        logic [7:0]  char_third;
        logic [7:0]  char_fourth;
    } t_in_word;

    typedef struct packed {
        logic [7:0]            segments;
        logic [PlaceWidth-1:0] active_digit;
    } t_out_word;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = BlankGlyph;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] letter_glyph(input logic [4:0] l);
        logic [7:0] g;
        case (l)
            5'd0:    g = 8'h77;
            5'd1:    g = 8'h7C;
            5'd2:    g = 8'h39;
            5'd3:    g = 8'h7E;
            5'd4:    g = 8'h79;
            5'd5:    g = 8'h71;
            5'd6:    g = 8'h3D;
            5'd7:    g = 8'h76;
            5'd8:    g = 8'h30;
            5'd9:    g = 8'h1E;
            5'd11:   g = 8'h38;
            5'd14:   g = 8'h7C;
            5'd15:   g = 8'h73;
            5'd17:   g = 8'h70;
            5'd18:   g = 8'h6D;
            5'd19:   g = 8'h78;
            5'd20:   g = 8'h3E;
            5'd24:   g = 8'h6E;
            5'd25:   g = 8'h1B;
            default: g = BlankGlyph;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] char_glyph(input logic [7:0] c);
        logic [7:0] g;
        logic [7:0] off;
        g = BlankGlyph;
        if (c >= 8'h30 && c <= 8'h39) begin
            off = c - 8'h30;
            g = digit_glyph(off[3:0]);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            off = c - 8'h41;
            g = letter_glyph(off[4:0]);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            off = c - 8'h61;
            g = letter_glyph(off[4:0]);
        end
        return g;
    endfunction

endpackage

### rtl/core/ssmd_if.sv
interface ssmd_in_if;
    logic                valid;
    logic                ready;
    ssmd_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ssmd_out_if;
    logic                valid;
    logic                ready;
    ssmd_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/seven_segment_mux_display.sv
// Four-place multiplexed seven-segment driver. A tick word advances the scan place and
// returns that place's pattern and index; the first tick after reset shows place 1. A text
// word maps four characters to glyphs. A number word of 10000000 or more sets every place
// to 9; a smaller one goes through a shift-and-add-3 binary to decimal converter, one bit
// per cycle over 24 bits, then a done state writes the patterns; the block takes no new
// word until it is back in idle. Tick results sit in an output register; a new word is taken
// only while that register is empty or being drained.
module seven_segment_mux_display (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ssmd_in_if.sink          i_in,
    ssmd_out_if.source       o_out
);

    localparam int CountWidth = $clog2(ssmd_pkg::BinWidth + 1);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StConv = 2'd1;
    localparam logic [1:0] StDone = 2'd2;

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    logic [CountWidth-1:0]              r_count;
    logic [CountWidth-1:0]              n_count;
    logic [ssmd_pkg::BinWidth-1:0]      r_bin;
    logic [ssmd_pkg::BinWidth-1:0]      n_bin;
    logic [ssmd_pkg::BcdWidth-1:0]      r_bcd;
    logic [ssmd_pkg::BcdWidth-1:0]      n_bcd;
    logic [7:0]                         r_patterns [ssmd_pkg::NumPlaces];
    logic [7:0]                         n_patterns [ssmd_pkg::NumPlaces];
    logic [ssmd_pkg::PlaceWidth-1:0]    r_scan_index;
    logic [ssmd_pkg::PlaceWidth-1:0]    n_scan_index;
    logic                               r_out_valid;
    logic                               n_out_valid;
    ssmd_pkg::t_out_word                r_out_word;
    ssmd_pkg::t_out_word                n_out_word;

    logic                               in_ready;
    logic                               in_accept;
    logic [3:0]                         dig [ssmd_pkg::BcdDigits];
    logic [3:0]                         win [ssmd_pkg::NumPlaces];
    logic [ssmd_pkg::PlaceWidth-1:0]    point_place;
    logic                               point_on;

    function automatic logic [ssmd_pkg::BcdWidth-1:0] dabble_step(
        input logic [ssmd_pkg::BcdWidth-1:0] bcd,
        input logic                          bit_in
    );
        logic [ssmd_pkg::BcdWidth-1:0] adj;
        adj = bcd;
        for (int k = 0; k < ssmd_pkg::BcdDigits; k++) begin
            if (adj[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = adj[k*4 +: 4] + 4'd3;
            end
        end
        return {adj[ssmd_pkg::BcdWidth-2:0], bit_in};
    endfunction

    assign in_ready    = (r_state == StIdle) && (!r_out_valid || o_out.ready);
    assign in_accept   = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    always_comb begin
        for (int k = 0; k < ssmd_pkg::BcdDigits; k++) begin
            dig[k] = r_bcd[k*4 +: 4];
        end
        // window of four digits and decimal point by magnitude
        if (dig[6] != 4'd0) begin
            win[0] = dig[6]; win[1] = dig[5]; win[2] = dig[4]; win[3] = dig[3];
            point_on = 1'b0; point_place = 2'd0;
        end else if (dig[5] != 4'd0) begin
            win[0] = dig[5]; win[1] = dig[4]; win[2] = dig[3]; win[3] = dig[2];
            point_on = 1'b1; point_place = 2'd1;
        end else if (dig[4] != 4'd0) begin
            win[0] = dig[4]; win[1] = dig[3]; win[2] = dig[2]; win[3] = dig[1];
            point_on = 1'b1; point_place = 2'd2;
        end else begin
            win[0] = dig[3]; win[1] = dig[2]; win[2] = dig[1]; win[3] = dig[0];
            point_on = 1'b1; point_place = 2'd3;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_bin        = r_bin;
        n_bcd        = r_bcd;
        n_patterns   = r_patterns;
        n_scan_index = r_scan_index;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_word   = r_out_word;
        case (r_state)
            StIdle: begin
                if (in_accept) begin
                    case (i_in.data.kind)
                        ssmd_pkg::KindTick: begin
                            n_scan_index            = r_scan_index + 1'b1;
                            n_out_valid             = 1'b1;
                            n_out_word.segments     = r_patterns[n_scan_index];
                            n_out_word.active_digit = n_scan_index;
                        end
                        ssmd_pkg::KindText: begin
                            n_patterns[0] = ssmd_pkg::char_glyph(i_in.data.char_first);
                            n_patterns[1] = ssmd_pkg::char_glyph(i_in.data.char_second);
                            n_patterns[2] = ssmd_pkg::char_glyph(i_in.data.char_third);
                            n_patterns[3] = ssmd_pkg::char_glyph(i_in.data.char_fourth);
                        end
                        ssmd_pkg::KindNumber: begin
                            if (i_in.data.number >= ssmd_pkg::SatLimit) begin
                                for (int p = 0; p < ssmd_pkg::NumPlaces; p++) begin
                                    n_patterns[p] = ssmd_pkg::digit_glyph(4'd9);
                                end
                            end else begin
                                n_bin   = i_in.data.number[ssmd_pkg::BinWidth-1:0];
                                n_bcd   = '0;
                                n_count = CountWidth'(ssmd_pkg::BinWidth);
                                n_state = StConv;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            StConv: begin
                n_bcd   = dabble_step(r_bcd, r_bin[ssmd_pkg::BinWidth-1]);
                n_bin   = {r_bin[ssmd_pkg::BinWidth-2:0], 1'b0};
                n_count = r_count - 1'b1;
                if (r_count == CountWidth'(1)) begin
                    n_state = StDone;
                end
            end
            StDone: begin
                for (int p = 0; p < ssmd_pkg::NumPlaces; p++) begin
                    n_patterns[p] = ssmd_pkg::digit_glyph(win[p]);
                end
                if (point_on) begin
                    n_patterns[point_place] = n_patterns[point_place] | ssmd_pkg::PointBit;
                end
                n_state = StIdle;
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= StIdle;
            r_count      <= '0;
            r_scan_index <= '0;
            r_out_valid  <= 1'b0;
            for (int p = 0; p < ssmd_pkg::NumPlaces; p++) begin
                r_patterns[p] <= ssmd_pkg::BlankGlyph;
            end
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_scan_index <= n_scan_index;
            r_out_valid  <= n_out_valid;
            r_patterns   <= n_patterns;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_out_word <= n_out_word;
    end

    // no word taken while converting
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> !i_in.ready)
        else $error("input ready while converter busy");

    // conversion counter never runs out inside the loop
    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StConv) |-> (r_count != '0))
        else $error("conversion counter at zero while converting");

    // a tick loads the output register with the next scan place
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.data.kind == ssmd_pkg::KindTick) |=>
        (r_out_valid && r_out_word.active_digit == r_scan_index &&
         r_scan_index == $past(r_scan_index) + 1'b1))
        else $error("tick result or scan index wrong");

    // only a tick produces a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(in_accept && i_in.data.kind == ssmd_pkg::KindTick)) |=>
        !r_out_valid)
        else $error("result without a tick");

endmodule
